[rtl/tlca_pkg.sv]
package tlca_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int EDGE_CAP  = 2 * (MAX_NODES - 1);
  localparam int EDGE_AW   = $clog2(EDGE_CAP);
  localparam int DIST_W    = 26;
  localparam int K_W       = 12;
  localparam int KX_W      = 14;
  localparam int OP_W      = 3;
  localparam int WIN_W     = 16;
  localparam int CFG_AW    = 2;
  localparam int ST_W      = 5;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 3'd1;
  localparam logic [OP_W-1:0] OP_LCA   = 3'd2;
  localparam logic [OP_W-1:0] OP_DIST  = 3'd3;
  localparam logic [OP_W-1:0] OP_ANC   = 3'd4;
  localparam logic [OP_W-1:0] OP_KTH   = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_NOBUILD = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ROOT       = 2'd1;

  // sequencer steps
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_DISP  = 5'd1;
  localparam logic [ST_W-1:0] S_EDGE  = 5'd2;
  localparam logic [ST_W-1:0] S_CLR   = 5'd3;
  localparam logic [ST_W-1:0] S_ROOT  = 5'd4;
  localparam logic [ST_W-1:0] S_POP   = 5'd5;
  localparam logic [ST_W-1:0] S_POPW  = 5'd6;
  localparam logic [ST_W-1:0] S_UDEP  = 5'd7;
  localparam logic [ST_W-1:0] S_SCAN  = 5'd8;
  localparam logic [ST_W-1:0] S_SCANW = 5'd9;
  localparam logic [ST_W-1:0] S_CHK   = 5'd10;
  localparam logic [ST_W-1:0] S_LFA   = 5'd11;
  localparam logic [ST_W-1:0] S_LFB   = 5'd12;
  localparam logic [ST_W-1:0] S_LFC   = 5'd13;
  localparam logic [ST_W-1:0] S_QA    = 5'd14;
  localparam logic [ST_W-1:0] S_QB    = 5'd15;
  localparam logic [ST_W-1:0] S_M1    = 5'd16;
  localparam logic [ST_W-1:0] S_M1W   = 5'd17;
  localparam logic [ST_W-1:0] S_MCMP  = 5'd18;
  localparam logic [ST_W-1:0] S_M2    = 5'd19;
  localparam logic [ST_W-1:0] S_M2P   = 5'd20;
  localparam logic [ST_W-1:0] S_M2Q   = 5'd21;
  localparam logic [ST_W-1:0] S_F1    = 5'd22;
  localparam logic [ST_W-1:0] S_F2    = 5'd23;
  localparam logic [ST_W-1:0] S_F3    = 5'd24;
  localparam logic [ST_W-1:0] S_MEND  = 5'd25;
  localparam logic [ST_W-1:0] S_KSEL  = 5'd26;
  localparam logic [ST_W-1:0] S_G0    = 5'd27;
  localparam logic [ST_W-1:0] S_GJ    = 5'd28;
  localparam logic [ST_W-1:0] S_GJW   = 5'd29;
  localparam logic [ST_W-1:0] S_GEND  = 5'd30;
  localparam logic [ST_W-1:0] S_DONE  = 5'd31;

  typedef struct packed {
    logic [ST_W-1:0] step;
    logic            accept;
  } tlca_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            built;
    logic            in_range;
    logic            u_last;
    logic            sp_zero;
    logic            e_end;
    logic            hit;
    logic            li_last;
    logic            jump;
    logic            i_zero;
    logic            pq_eq;
    logic            up_fail;
  } tlca_sts_t;

endpackage

[rtl/tlca_ram.sv]
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tlca_ctrl.sv]
module tlca_ctrl import tlca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tlca_sts_t sts_i,
  output tlca_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  logic [ST_W-1:0] state_q, state_d;
  logic            query_op;

  assign query_op = (sts_i.op == OP_LCA) || (sts_i.op == OP_DIST) ||
                    (sts_i.op == OP_ANC) || (sts_i.op == OP_KTH);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_DISP;
      S_DISP: begin
        if (sts_i.op == OP_ADD) state_d = S_EDGE;
        else if (sts_i.op == OP_BUILD) state_d = S_CLR;
        else if (query_op && sts_i.built && sts_i.in_range) state_d = S_QA;
        else state_d = S_DONE;
      end
      S_EDGE:  state_d = S_DONE;
      S_CLR:   if (sts_i.u_last) state_d = S_ROOT;
      S_ROOT:  state_d = S_POP;
      S_POP:   state_d = sts_i.sp_zero ? S_LFA : S_POPW;
      S_POPW:  state_d = S_UDEP;
      S_UDEP:  state_d = S_SCAN;
      S_SCAN:  state_d = sts_i.e_end ? S_POP : S_SCANW;
      S_SCANW: state_d = sts_i.hit ? S_CHK : S_SCAN;
      S_CHK:   state_d = S_SCAN;
      S_LFA:   state_d = S_LFB;
      S_LFB:   state_d = S_LFC;
      S_LFC:   state_d = (sts_i.u_last && sts_i.li_last) ? S_DONE : S_LFA;
      S_QA:    state_d = S_QB;
      S_QB:    state_d = (sts_i.op == OP_ANC) ? S_G0 : S_M1;
      S_M1: begin
        if (sts_i.jump) state_d = S_M1W;
        else if (sts_i.i_zero) state_d = S_MCMP;
      end
      S_M1W:   state_d = sts_i.i_zero ? S_MCMP : S_M1;
      S_MCMP:  state_d = sts_i.pq_eq ? S_MEND : S_M2;
      S_M2:    state_d = S_M2P;
      S_M2P:   state_d = S_M2Q;
      S_M2Q:   state_d = sts_i.i_zero ? S_F1 : S_M2;
      S_F1:    state_d = S_F2;
      S_F2:    state_d = S_F3;
      S_F3:    state_d = S_MEND;
      S_MEND:  state_d = (sts_i.op == OP_KTH) ? S_KSEL : S_DONE;
      S_KSEL:  state_d = S_G0;
      S_G0:    state_d = sts_i.up_fail ? S_DONE : S_GJ;
      S_GJ: begin
        if (sts_i.jump) state_d = S_GJW;
        else if (sts_i.i_zero) state_d = S_GEND;
      end
      S_GJW:   state_d = sts_i.i_zero ? S_GEND : S_GJ;
      S_GEND:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.step   = state_q;
  assign cmd_o.accept = (state_q == S_IDLE) && start_i;
  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);

endmodule

[rtl/tlca_datapath.sv]
module tlca_datapath import tlca_pkg::*; #(
  parameter int LIFT_LEVELS = 11,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tlca_cmd_t                cmd_i,
  output tlca_sts_t                sts_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [NODE_W-1:0]        node_a_i,
  input  logic [NODE_W-1:0]        node_b_i,
  input  logic [WIN_W-1:0]         edge_weight_i,
  input  logic signed [K_W-1:0]    k_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_AW-1:0]        cfg_addr_i,
  input  logic [CNT_W-1:0]         cfg_data_i,
  output logic [NODE_W-1:0]        node_result_o,
  output logic                     found_o,
  output logic [DIST_W-1:0]        distance_result_o,
  output logic [1:0]               status_o
);

  localparam int WW     = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
  localparam int LVL_W  = $clog2(LIFT_LEVELS);
  localparam int TAB_D  = LIFT_LEVELS * MAX_NODES;
  localparam int TAB_AW = $clog2(TAB_D);
  localparam int EW     = 2 * NODE_W + WW;

  function automatic logic [LVL_W-1:0] lift_bound(input logic [NODE_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int j = 1; j < LIFT_LEVELS; j++) begin
      if ((x >> j) != '0) r = LVL_W'(j);
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
                                                input logic [DIST_W-1:0] y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_W] ? '1 : s[DIST_W-1:0];
  endfunction

  function automatic logic signed [KX_W-1:0] zx(input logic [NODE_W-1:0] x);
    return $signed({{(KX_W-NODE_W){1'b0}}, x});
  endfunction

  function automatic logic [TAB_AW-1:0] taddr(input logic [LVL_W-1:0] l,
                                              input logic [NODE_W-1:0] u);
    return TAB_AW'({l, u});
  endfunction

  // config and persistent state
  logic [CNT_W-1:0]   ncnt_q, ncnt_d;
  logic [NODE_W-1:0]  root_q, root_d;
  logic [EDGE_AW-1:0] ecnt_q, ecnt_d;
  logic               built_q, built_d;
  // item registers
  logic [OP_W-1:0]    op_q, op_d;
  logic [NODE_W-1:0]  a_q, a_d, b_q, b_d;
  logic [WW-1:0]      w_q, w_d;
  logic signed [K_W-1:0] k_q, k_d;
  // build registers
  logic [NODE_W-1:0]  u_q, u_d, du_q, du_d, v_q, v_d;
  logic [WW-1:0]      vw_q, vw_d;
  logic [CNT_W-1:0]   sp_q, sp_d;
  logic [EDGE_AW-1:0] e_q, e_d;
  logic [LVL_W-1:0]   li_q, li_d;
  logic [DIST_W-1:0]  s1_q, s1_d;
  // query registers
  logic [NODE_W-1:0]  p_q, p_d, q_q, q_d, dp_q, dp_d, dq_q, dq_d;
  logic [NODE_W-1:0]  da_q, da_d, db_q, db_d, wn_q, wn_d, ap_q, ap_d, h_q, h_d;
  logic [DIST_W-1:0]  s_q, s_d, spp_q, spp_d;
  logic [LVL_W-1:0]   i_q, i_d, lg_q, lg_d;
  logic signed [KX_W-1:0] gk_q, gk_d;
  // result registers
  logic [NODE_W-1:0]  rn_q, rn_d;
  logic               rf_q, rf_d;
  logic [DIST_W-1:0]  rd_q, rd_d;
  logic [1:0]         rs_q, rs_d;

  // memory ports
  logic                dep_we, rch_we, rch_wdata, rch_rd, stk_we, edg_we, anc_we, ps_we;
  logic [NODE_W-1:0]   dep_waddr, dep_wdata, dep_raddr, dep_rd;
  logic [NODE_W-1:0]   rch_waddr, rch_raddr;
  logic [NODE_W-1:0]   stk_waddr, stk_wdata, stk_raddr, stk_rd;
  logic [EDGE_AW-1:0]  edg_raddr;
  logic [EW-1:0]       edg_wdata, edg_rd;
  logic [TAB_AW-1:0]   tab_waddr, tab_raddr;
  logic [NODE_W-1:0]   anc_wdata, anc_rd;
  logic [DIST_W-1:0]   ps_wdata, ps_rd;

  // combinational helpers
  logic [CNT_W-1:0]   n_eff;
  logic [NODE_W-1:0]  ea, eb, v_c;
  logic [WW-1:0]      ew;
  logic               hit;
  logic [CNT_W-1:0]   pow;
  logic signed [CNT_W:0] dif;
  logic [NODE_W-1:0]  tgt;
  logic               jump;
  logic signed [KX_W-1:0] k_x, left_c, alt_c, hdif;
  logic               swap;
  logic [NODE_W-1:0]  big_c;

  assign n_eff = (ncnt_q == '0) ? CNT_W'(1) :
                 (ncnt_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : ncnt_q;

  assign ea  = edg_rd[EW-1 -: NODE_W];
  assign eb  = edg_rd[WW +: NODE_W];
  assign ew  = edg_rd[WW-1:0];
  assign hit = (ea == u_q) || (eb == u_q);
  assign v_c = (ea == u_q) ? eb : ea;

  assign pow  = CNT_W'(1) << i_q;
  assign dif  = $signed({2'b00, dp_q}) - $signed({1'b0, pow});
  assign tgt  = (cmd_i.step == S_GJ) ? h_q : dq_q;
  assign jump = dif >= $signed({2'b00, tgt});

  assign k_x    = $signed({{(KX_W-K_W){k_q[K_W-1]}}, k_q});
  assign left_c = zx(da_q) - zx(dep_rd) + $signed(KX_W'(1));
  assign alt_c  = (zx(db_q) - zx(dep_rd)) - (k_x - left_c);
  assign hdif   = zx(dp_q) - gk_q;

  assign swap  = da_q < dep_rd;
  assign big_c = swap ? dep_rd : da_q;

  always_comb begin
    ncnt_d = ncnt_q; root_d = root_q; ecnt_d = ecnt_q; built_d = built_q;
    op_d = op_q; a_d = a_q; b_d = b_q; w_d = w_q; k_d = k_q;
    u_d = u_q; du_d = du_q; v_d = v_q; vw_d = vw_q; sp_d = sp_q; e_d = e_q;
    li_d = li_q; s1_d = s1_q;
    p_d = p_q; q_d = q_q; dp_d = dp_q; dq_d = dq_q; da_d = da_q; db_d = db_q;
    wn_d = wn_q; ap_d = ap_q; h_d = h_q; s_d = s_q; spp_d = spp_q;
    i_d = i_q; lg_d = lg_q; gk_d = gk_q;
    rn_d = rn_q; rf_d = rf_q; rd_d = rd_q; rs_d = rs_q;

    dep_we = 1'b0; dep_waddr = u_q; dep_wdata = '0; dep_raddr = a_q;
    rch_we = 1'b0; rch_waddr = u_q; rch_wdata = 1'b0; rch_raddr = v_c;
    stk_we = 1'b0; stk_waddr = sp_q[NODE_W-1:0]; stk_wdata = v_q;
    stk_raddr = NODE_W'(sp_q - CNT_W'(1));
    edg_we = 1'b0; edg_wdata = {a_q, b_q, w_q}; edg_raddr = e_q;
    anc_we = 1'b0; ps_we = 1'b0; tab_waddr = taddr('0, u_q);
    anc_wdata = '0; ps_wdata = '0; tab_raddr = taddr(i_q, p_q);

    if (cfg_we_i) begin
      if (cfg_addr_i == CFG_NODE_COUNT) ncnt_d = cfg_data_i;
      else if (cfg_addr_i == CFG_ROOT) root_d = cfg_data_i[NODE_W-1:0];
    end

    case (cmd_i.step)
      S_IDLE: begin
        if (cmd_i.accept) begin
          op_d = op_i; a_d = node_a_i; b_d = node_b_i;
          w_d = edge_weight_i[WW-1:0]; k_d = k_value_i;
        end
      end
      S_DISP: begin
        rn_d = '0; rf_d = 1'b0; rd_d = '0; rs_d = STAT_OK;
        if ((op_q == OP_LCA || op_q == OP_DIST || op_q == OP_ANC || op_q == OP_KTH)
            && !built_q) rs_d = STAT_NOBUILD;
        dep_raddr = a_q;
        u_d = '0;
      end
      S_EDGE: begin
        if (ecnt_q < EDGE_AW'(EDGE_CAP)) begin
          edg_we = 1'b1; ecnt_d = ecnt_q + EDGE_AW'(1); built_d = 1'b0;
        end else begin
          rs_d = STAT_FULL;
        end
      end
      S_CLR: begin
        dep_we = 1'b1; dep_waddr = u_q;
        rch_we = 1'b1; rch_waddr = u_q;
        anc_we = 1'b1; ps_we = 1'b1; tab_waddr = taddr('0, u_q);
        u_d = u_q + NODE_W'(1);
      end
      S_ROOT: begin
        sp_d = '0;
        if ({1'b0, root_q} < n_eff) begin
          anc_we = 1'b1; tab_waddr = taddr('0, root_q); anc_wdata = root_q;
          rch_we = 1'b1; rch_waddr = root_q; rch_wdata = 1'b1;
          stk_we = 1'b1; stk_waddr = '0; stk_wdata = root_q;
          sp_d = CNT_W'(1);
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          li_d = LVL_W'(1); u_d = '0;
        end else begin
          sp_d = sp_q - CNT_W'(1);
        end
      end
      S_POPW: begin
        u_d = stk_rd; dep_raddr = stk_rd;
      end
      S_UDEP: begin
        du_d = dep_rd; e_d = '0;
      end
      S_SCANW: begin
        v_d = v_c; vw_d = ew;
        if (!hit) e_d = e_q + EDGE_AW'(1);
      end
      S_CHK: begin
        if ({1'b0, v_q} < n_eff && !rch_rd && sp_q < CNT_W'(MAX_NODES)) begin
          rch_we = 1'b1; rch_waddr = v_q; rch_wdata = 1'b1;
          anc_we = 1'b1; ps_we = 1'b1; tab_waddr = taddr('0, v_q);
          anc_wdata = u_q; ps_wdata = DIST_W'(vw_q);
          dep_we = 1'b1; dep_waddr = v_q; dep_wdata = du_q + NODE_W'(1);
          stk_we = 1'b1;
          sp_d = sp_q + CNT_W'(1);
        end
        e_d = e_q + EDGE_AW'(1);
      end
      S_LFA: tab_raddr = taddr(li_q - LVL_W'(1), u_q);
      S_LFB: begin
        s1_d = ps_rd;
        tab_raddr = taddr(li_q - LVL_W'(1), anc_rd);
      end
      S_LFC: begin
        anc_we = 1'b1; ps_we = 1'b1; tab_waddr = taddr(li_q, u_q);
        anc_wdata = anc_rd; ps_wdata = sat_add(s1_q, ps_rd);
        u_d = u_q + NODE_W'(1);
        if (u_q == NODE_W'(MAX_NODES - 1)) begin
          u_d = '0;
          if (li_q == LVL_W'(LIFT_LEVELS - 1)) built_d = 1'b1;
          else li_d = li_q + LVL_W'(1);
        end
      end
      S_QA: begin
        da_d = dep_rd; dep_raddr = b_q;
      end
      S_QB: begin
        db_d = dep_rd;
        if (op_q == OP_ANC) begin
          p_d = a_q; dp_d = da_q; gk_d = k_x;
        end else begin
          p_d  = swap ? b_q : a_q;
          dp_d = big_c;
          q_d  = swap ? a_q : b_q;
          dq_d = swap ? da_q : dep_rd;
          i_d  = lift_bound(big_c);
          lg_d = lift_bound(big_c);
          s_d  = '0;
        end
      end
      S_M1: begin
        tab_raddr = taddr(i_q, p_q);
        if (!jump && i_q != '0) i_d = i_q - LVL_W'(1);
      end
      S_M1W: begin
        s_d  = sat_add(s_q, ps_rd);
        p_d  = anc_rd;
        dp_d = dp_q - pow[NODE_W-1:0];
        if (i_q != '0) i_d = i_q - LVL_W'(1);
      end
      S_MCMP: begin
        wn_d = p_q; i_d = lg_q;
      end
      S_M2: tab_raddr = taddr(i_q, p_q);
      S_M2P: begin
        ap_d = anc_rd; spp_d = ps_rd;
        tab_raddr = taddr(i_q, q_q);
      end
      S_M2Q: begin
        if (ap_q != anc_rd) begin
          s_d = sat_add(s_q, sat_add(spp_q, ps_rd));
          p_d = ap_q; q_d = anc_rd;
        end
        if (i_q != '0) i_d = i_q - LVL_W'(1);
      end
      S_F1: tab_raddr = taddr('0, p_q);
      S_F2: begin
        ap_d = anc_rd; spp_d = ps_rd;
        tab_raddr = taddr('0, q_q);
      end
      S_F3: begin
        s_d  = sat_add(s_q, sat_add(spp_q, ps_rd));
        wn_d = ap_q;
      end
      S_MEND: begin
        dep_raddr = wn_q;
        if (op_q == OP_LCA) begin
          rn_d = wn_q; rf_d = 1'b1;
        end else if (op_q == OP_DIST) begin
          rd_d = s_q; rf_d = 1'b1;
        end
      end
      S_KSEL: begin
        if (k_x <= left_c) begin
          p_d = a_q; dp_d = da_q; gk_d = k_x - $signed(KX_W'(1));
        end else begin
          p_d = b_q; dp_d = db_q; gk_d = alt_c;
        end
      end
      S_G0: begin
        h_d = hdif[NODE_W-1:0];
        i_d = lift_bound(dp_q);
      end
      S_GJ: begin
        tab_raddr = taddr(i_q, p_q);
        if (!jump && i_q != '0) i_d = i_q - LVL_W'(1);
      end
      S_GJW: begin
        p_d  = anc_rd;
        dp_d = dp_q - pow[NODE_W-1:0];
        if (i_q != '0) i_d = i_q - LVL_W'(1);
      end
      S_GEND: begin
        rn_d = p_q; rf_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q  <= CNT_W'(MAX_NODES);
      root_q  <= '0;
      ecnt_q  <= '0;
      built_q <= 1'b0;
    end else begin
      ncnt_q  <= ncnt_d;
      root_q  <= root_d;
      ecnt_q  <= ecnt_d;
      built_q <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; w_q <= w_d; k_q <= k_d;
    u_q <= u_d; du_q <= du_d; v_q <= v_d; vw_q <= vw_d; sp_q <= sp_d; e_q <= e_d;
    li_q <= li_d; s1_q <= s1_d;
    p_q <= p_d; q_q <= q_d; dp_q <= dp_d; dq_q <= dq_d; da_q <= da_d; db_q <= db_d;
    wn_q <= wn_d; ap_q <= ap_d; h_q <= h_d; s_q <= s_d; spp_q <= spp_d;
    i_q <= i_d; lg_q <= lg_d; gk_q <= gk_d;
    rn_q <= rn_d; rf_q <= rf_d; rd_q <= rd_d; rs_q <= rs_d;
  end

  tlca_ram #(.WIDTH(EW), .DEPTH(EDGE_CAP)) u_edge_ram (
    .clk_i, .we_i(edg_we), .waddr_i(ecnt_q), .wdata_i(edg_wdata),
    .raddr_i(edg_raddr), .rdata_o(edg_rd)
  );

  tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_depth_ram (
    .clk_i, .we_i(dep_we), .waddr_i(dep_waddr), .wdata_i(dep_wdata),
    .raddr_i(dep_raddr), .rdata_o(dep_rd)
  );

  tlca_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_reach_ram (
    .clk_i, .we_i(rch_we), .waddr_i(rch_waddr), .wdata_i(rch_wdata),
    .raddr_i(rch_raddr), .rdata_o(rch_rd)
  );

  tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  tlca_ram #(.WIDTH(NODE_W), .DEPTH(TAB_D)) u_anc_ram (
    .clk_i, .we_i(anc_we), .waddr_i(tab_waddr), .wdata_i(anc_wdata),
    .raddr_i(tab_raddr), .rdata_o(anc_rd)
  );

  tlca_ram #(.WIDTH(DIST_W), .DEPTH(TAB_D)) u_psum_ram (
    .clk_i, .we_i(ps_we), .waddr_i(tab_waddr), .wdata_i(ps_wdata),
    .raddr_i(tab_raddr), .rdata_o(ps_rd)
  );

  assign sts_o.op       = op_q;
  assign sts_o.built    = built_q;
  assign sts_o.in_range = ({1'b0, a_q} < n_eff) && (op_q == OP_ANC || {1'b0, b_q} < n_eff);
  assign sts_o.u_last   = (u_q == NODE_W'(MAX_NODES - 1));
  assign sts_o.sp_zero  = (sp_q == '0);
  assign sts_o.e_end    = (e_q == ecnt_q);
  assign sts_o.hit      = hit;
  assign sts_o.li_last  = (li_q == LVL_W'(LIFT_LEVELS - 1));
  assign sts_o.jump     = jump;
  assign sts_o.i_zero   = (i_q == '0);
  assign sts_o.pq_eq    = (p_q == q_q);
  assign sts_o.up_fail  = gk_q[KX_W-1] | hdif[KX_W-1];

  assign node_result_o     = rn_q;
  assign found_o           = rf_q;
  assign distance_result_o = rd_q;
  assign status_o          = rs_q;

endmodule

[rtl/tree_lca_binary_lifting.sv]
// Weighted tree query engine: lowest common ancestor by binary lifting.
// Command channel: an op is taken on a rising edge with start high and busy low;
// busy stays high until the answer has gone out. The answer appears on the
// result ports for one cycle with done_o high; the receiver cannot stall it.
// Config channel (node_count at index 0, root_node at index 1) is always ready
// and is to be written only while busy is low.
// Each op's run time is limited by the single read port of each table memory.
// Add edge stores the edge; unused ops and rejected queries go straight to done.
// lca / distance level the deeper node by upward jumps, then lift both nodes
// together while they still differ after levelling; ancestor walks up by
// jumps and stops early when k is out of range; kth runs the lca steps, then
// the same ancestor walk; build runs a clearing sweep over all nodes, a walk
// from the root that handles each reached node (every pop scans the whole edge
// list) and a fill of each higher lift table level.
// One op at a time: the next is taken only once busy has dropped.
// Reset empties the edge list, drops the built tree (queries then report
// status 2) and sets node_count to 1024 and root_node to 0.
module tree_lca_binary_lifting import tlca_pkg::*; #(
  parameter int LIFT_LEVELS = 11,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op_i,
  input  logic [NODE_W-1:0]     node_a_i,
  input  logic [NODE_W-1:0]     node_b_i,
  input  logic [WIN_W-1:0]      edge_weight_i,
  input  logic signed [K_W-1:0] k_value_i,
  output logic                  done_o,
  output logic [NODE_W-1:0]     node_result_o,
  output logic                  found_o,
  output logic [DIST_W-1:0]     distance_result_o,
  output logic [1:0]            status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [CNT_W-1:0]      cfg_data_i
);

  tlca_cmd_t cmd;
  tlca_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tlca_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  tlca_datapath #(
    .LIFT_LEVELS (LIFT_LEVELS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i, .node_a_i, .node_b_i, .edge_weight_i, .k_value_i,
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_addr_i, .cfg_data_i,
    .node_result_o, .found_o, .distance_result_o, .status_o
  );

endmodule

[rtl/tlca_checker.sv]
module tlca_checker import tlca_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [NODE_W-1:0] node_result_o,
  input logic              found_o,
  input logic [DIST_W-1:0] distance_result_o,
  input logic [1:0]        status_o
);

  // an accepted op keeps the block busy until its answer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted op did not raise busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("answer strobe outside a busy period");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("answer strobe longer than one cycle");

  a_nobuild_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_NOBUILD) |->
      (!found_o && node_result_o == '0 && distance_result_o == '0))
    else $error("query before build returned data");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == STAT_OK))
    else $error("found answer with error status");

endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (.*);
